### rtl/core/btc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_pkg
// Shared constants, register indexes and controller/datapath types for the
// block transposition cipher.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int BLOCK_SIZE = 5;   // bytes per block, 2 .. 5
  localparam int KEY_COUNT  = 5;   // key registers in the register map
  localparam int KEY_W      = 3;
  localparam int IDX_W      = 3;   // holds 0 .. BLOCK_SIZE
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd1;

  // Mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic [7:0]       byte_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // a request is taken this cycle
    logic load_out;  // load the output register from the bank
    idx_t idx;       // bank position to emit
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic flush;      // the byte on the input closes the block
    logic emit_last;  // idx is the final position of the bank
  } dp_stat_t;

endpackage

### rtl/core/block_transposition_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_transposition_cipher
// Collects a byte stream into blocks and emits each block permuted by key.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte per request; in_tlast marks the final byte of the text.
//   out_* : one byte per request; out_tlast marks the last byte of a block.
//   cfg_* : write mode (index 0) and key_0..key_4 (indexes 1..5) while idle.
// A full block is gathered (encode) or scattered (decode) by the keys; a
// block cut short by in_tlast is emitted unchanged.
// The byte that closes the block sends the sequencer to its emit state; the
// first byte of the block is then loaded into the output register once free.
// Throughput: one byte per cycle while filling, then one byte per cycle
// while emitting and out_tready stays high; in_tready is held low in
// emission. The single emit bank, read out byte by byte through the output
// register, sets this limit, so no byte of a new block enters meanwhile.
// Reset (rst_n low, synchronous): mode encode, identity key, empty block,
// out_tvalid low.
// Stall: when out_tready is low while out_tvalid is high, the output
// register holds its byte and the emit walk stops; input stays held off
// until the last byte of the block is loaded into the output register.
// ----------------------------------------------------------------------------
module block_transposition_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // stream_end
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic                           out_tlast,  // block_last
  // configuration
  input  logic                           cfg_we,
  input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import btc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer: handshakes and emit walk
  btc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Storage and permutation
  btc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  // Never take a request and load the output register in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !cmd.load_out)
    else $error("capture and emit overlap");

  // A closing byte drops in_tready for the emission
  a_flush_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture && stat.flush) |=> !in_tready)
    else $error("input not held off after block close");

  // Hold a waiting output request steady while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output request changed while stalled");

endmodule

### rtl/core/btc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_datapath
// Config registers, block buffer, permutation into the emit bank and the
// output data register.
// ----------------------------------------------------------------------------
module btc_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  btc_pkg::byte_t                 in_byte,
  input  logic                           in_end,
  input  btc_pkg::ctrl_cmd_t             cmd,
  output btc_pkg::dp_stat_t              stat,
  output btc_pkg::byte_t                 out_byte,
  output logic                           out_last
);
  import btc_pkg::*;

  logic  mode_r;
  key_t  key_r   [KEY_COUNT];
  byte_t buf_r   [BLOCK_SIZE];
  byte_t bank_r  [BLOCK_SIZE];
  idx_t  fill_r, fill_nxt;
  idx_t  cnt_r;
  byte_t out_byte_r;
  logic  out_last_r;

  byte_t blk  [BLOCK_SIZE];
  byte_t perm [BLOCK_SIZE];
  logic  full;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      for (int i = 0; i < KEY_COUNT; i++) key_r[i] <= KEY_W'(i);
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) mode_r <= cfg_wdata[0];
      for (int i = 0; i < KEY_COUNT; i++) begin
        if (cfg_index == CFG_KEY0 + CFG_IDX_W'(i)) key_r[i] <= cfg_wdata;
      end
    end
  end

  // Block as it stands once the incoming byte is placed
  always_comb begin
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      blk[i] = (fill_r == IDX_W'(i)) ? in_byte : buf_r[i];
    end
  end

  assign full = (fill_r == IDX_W'(BLOCK_SIZE - 1));

  // Gather, scatter or pass through
  always_comb begin
    for (int p = 0; p < BLOCK_SIZE; p++) begin
      perm[p] = blk[p];
      if (full) begin
        if (mode_r == MODE_ENCODE) begin
          perm[p] = '0;
          for (int k = 0; k < BLOCK_SIZE; k++) begin
            if (key_r[p] == KEY_W'(k)) perm[p] = blk[k];
          end
        end else begin
          for (int j = 0; j < BLOCK_SIZE; j++) begin
            if (key_r[j] == KEY_W'(p)) perm[p] = blk[j];
          end
        end
      end
    end
  end

  assign stat.flush     = full || in_end;
  assign stat.emit_last = (cmd.idx == cnt_r - IDX_W'(1));

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.capture) begin
      fill_nxt = stat.flush ? '0 : fill_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else        fill_r <= fill_nxt;
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < BLOCK_SIZE; i++) begin
        if (fill_r == IDX_W'(i)) buf_r[i] <= in_byte;
      end
      if (stat.flush) begin
        for (int i = 0; i < BLOCK_SIZE; i++) bank_r[i] <= perm[i];
        cnt_r <= fill_r + IDX_W'(1);
      end
    end
    if (cmd.load_out) begin
      out_byte_r <= bank_r[cmd.idx];
      out_last_r <= stat.emit_last;
    end
  end

  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

endmodule

### rtl/core/btc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_ctrl
// Fill/emit sequencer: gates input requests, walks the emit bank and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module btc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  btc_pkg::dp_stat_t   stat,
  output btc_pkg::ctrl_cmd_t  cmd
);
  import btc_pkg::*;

  localparam logic ST_FILL = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  idx_t idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free   = !out_valid_r || out_tready;
  assign in_tready   = (state_r == ST_FILL);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.load_out = (state_r == ST_EMIT) && slot_free;
  assign cmd.idx     = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_FILL: begin
        if (cmd.capture && stat.flush) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (cmd.load_out) begin
          idx_nxt = idx_r + IDX_W'(1);
          if (stat.emit_last) state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### verif/tb_block_transposition_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_transposition_cipher
// Self-checking bench for the block transposition cipher. A cycle-free model
// of the gather/scatter permutation predicts every output byte from each
// accepted input request. A monitor compares each output request, field by
// field, with the oldest prediction. Directed cases come first: the identity
// key, short blocks flushed at stream end, reversed decode and keys out of
// range. Random phases follow, with random keys and random stalls.
// ----------------------------------------------------------------------------
module tb_block_transposition_cipher;
  import btc_pkg::*;

  localparam int N             = BLOCK_SIZE;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 25;

  typedef key_t key_set_t [KEY_COUNT];

  // One predicted output request.
  typedef struct {
    byte_t data;
    logic  last;
  } out_rec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] data_byte
  logic                  in_tlast;   // stream_end
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // [7:0] out_byte
  logic                  out_tlast;  // block_last
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the block state and the register file.
  logic     mode_q;
  key_t     key_q [KEY_COUNT];
  byte_t    blk_q [N];
  int       fill_q;
  out_rec_t pending_out [$];

  // Traffic shaping, changed per phase.
  int  gap_pct;
  int  stall_pct;
  bit  quiet;

  int  errors;
  int  bytes_in;
  int  bytes_out;
  int  keyed_blocks;
  int  short_blocks;

  block_transposition_cipher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------
  function automatic void model_reset();
    mode_q = MODE_ENCODE;
    for (int i = 0; i < KEY_COUNT; i++) key_q[i] = key_t'(i);
    for (int i = 0; i < N; i++) blk_q[i] = '0;
    fill_q = 0;
  endfunction

  // Take one byte into the shadow block; queue whatever the block emits.
  function automatic void model_take_byte(byte_t b, logic e);
    byte_t perm [N];
    if (fill_q >= N) fill_q = 0;
    blk_q[fill_q] = b;
    fill_q++;

    if (fill_q < N) begin
      // Nothing comes out unless the stream ends here; a short block goes
      // out in arrival order, unpermuted.
      if (!e) return;
      for (int j = 0; j < fill_q; j++) pending_out.push_back('{blk_q[j], j + 1 == fill_q});
      short_blocks++;
      fill_q = 0;
      return;
    end

    if (mode_q == MODE_ENCODE) begin
      // Gather: position j pulls block byte key_j, zero when key_j is past
      // the block.
      for (int j = 0; j < N; j++) perm[j] = (key_q[j] < N) ? blk_q[key_q[j]] : '0;
    end else begin
      // Scatter onto a copy of the block; later positions win, keys past the
      // block write nothing.
      perm = blk_q;
      for (int j = 0; j < N; j++) if (key_q[j] < N) perm[key_q[j]] = blk_q[j];
    end
    for (int j = 0; j < N; j++) pending_out.push_back('{perm[j], j + 1 == N});
    keyed_blocks++;
    fill_q = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Write one register; hold the enable for a single edge, then drop it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) mode_q = val[0];
    else if (idx >= CFG_KEY0 && idx < CFG_KEY0 + KEY_COUNT) key_q[idx - CFG_KEY0] = val;
    @(posedge clk);
  endtask

  task automatic configure(logic m, key_set_t ks);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    for (int i = 0; i < KEY_COUNT; i++) write_reg(CFG_IDX_W'(CFG_KEY0 + i), ks[i]);
  endtask

  // Send one byte request, with an optional random gap in front of it.
  task automatic send_byte(byte_t b, logic e);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_in++;
    model_take_byte(b, e);
  endtask

  // Drop valid, wait for every predicted byte, then let the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output backpressure: random bursts of low ready, none while quiet.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_out.size() == 0) begin
        $error("unexpected output request: out_byte %02h block_last %0b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_out.pop_front();
        bytes_out++;
        if (out_tdata !== want.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("block_last mismatch: expected %0b, actual %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset key is the identity in encode mode: a block passes straight through.
  task automatic test_reset_defaults();
    byte_t pattern [N] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01};
    for (int i = 0; i < N; i++) send_byte(pattern[i], 1'b0);
    wait_idle();
  endtask

  // Short blocks cut by stream end come out unchanged, including one byte.
  task automatic test_partial_flush();
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h3C, 1'b1);
    wait_idle();
  endtask

  // Reverse key in decode mode, on a full block that also ends the stream.
  task automatic test_decode_reverse();
    key_set_t ks = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    configure(MODE_DECODE, ks);
    for (int i = 0; i < N; i++) send_byte(byte_t'(8'h11 * (i + 1)), i == N - 1);
    wait_idle();
  endtask

  // Keys past the block: zeros in encode, skipped writes in decode. Writes to
  // indexes past the key registers must not disturb anything.
  task automatic test_key_out_of_range();
    key_set_t enc_keys = '{3'd7, 3'd5, 3'd6, 3'd0, 3'd2};
    key_set_t dec_keys = '{3'd1, 3'd1, 3'd7, 3'd0, 3'd4};
    configure(MODE_ENCODE, enc_keys);
    write_reg(CFG_IDX_W'(CFG_KEY0 + KEY_COUNT), '1);
    write_reg(CFG_IDX_W'(CFG_KEY0 + KEY_COUNT + 1), '0);
    for (int i = 0; i < N; i++) send_byte(byte_t'($urandom_range(1, 255)), 1'b0);
    wait_idle();
    configure(MODE_DECODE, dec_keys);
    for (int i = 0; i < N; i++) send_byte(byte_t'($urandom_range(1, 255)), 1'b0);
    wait_idle();
  endtask

  // Random phases: mostly full blocks, now and then a stream end that cuts a
  // block short. Each phase ends the stream so the next key set starts clean.
  task automatic test_random_traffic();
    key_set_t ks;
    logic     m;
    int       kind;
    int       pick;
    key_t     swap;
    for (int ph = 0; ph < PHASES; ph++) begin
      // First phases pin the extreme key sets, the rest draw their own.
      case (ph)
        0: begin m = MODE_ENCODE; for (int i = 0; i < KEY_COUNT; i++) ks[i] = '0; end
        1: begin m = MODE_DECODE; for (int i = 0; i < KEY_COUNT; i++) ks[i] = '0; end
        2: begin m = MODE_DECODE; for (int i = 0; i < KEY_COUNT; i++) ks[i] = '1; end
        default: begin
          m    = logic'($urandom_range(0, 1));
          kind = $urandom_range(0, 3);
          for (int i = 0; i < KEY_COUNT; i++) ks[i] = key_t'(i);
          for (int i = N - 1; i > 0; i--) begin
            pick     = $urandom_range(0, i);
            swap     = ks[i];
            ks[i]    = ks[pick];
            ks[pick] = swap;
          end
          if (kind == 2) ks[$urandom_range(0, N - 1)] = key_t'($urandom_range(N, 7));
          if (kind == 3) for (int i = 0; i < KEY_COUNT; i++) ks[i] = key_t'($urandom_range(0, 7));
        end
      endcase
      configure(m, ks);

      // Phase 1 runs with no idling at all; the last phase is quiet too.
      quiet     = (ph == PHASES - 1);
      gap_pct   = (ph == 1) ? 0 : $urandom_range(10, 40);
      stall_pct = (ph == 1) ? 0 : $urandom_range(10, 40);

      for (int n = 0; n < PHASE_BYTES; n++)
        send_byte(byte_t'($urandom_range(0, 255)),
                  (n == PHASE_BYTES - 1) || ($urandom_range(0, 9) == 0));
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    gap_pct   = 25;
    stall_pct = 25;
    errors    = 0;
    bytes_in  = 0;
    bytes_out = 0;
    keyed_blocks = 0;
    short_blocks = 0;
    model_reset();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_partial_flush();
    test_decode_reverse();
    test_key_out_of_range();
    test_random_traffic();

    if (pending_out.size() != 0) begin
      $error("%0d predicted output bytes never arrived", pending_out.size());
      errors++;
    end

    $display("Run covered %0d input bytes and %0d output bytes in encode and decode modes:",
             bytes_in, bytes_out);
    $display("  %0d keyed blocks (in-range and out-of-range keys), %0d short blocks flushed",
             keyed_blocks, short_blocks);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/btc_pkg.sv
rtl/core/btc_datapath.sv
rtl/core/btc_ctrl.sv
rtl/core/block_transposition_cipher.sv
verif/tb_block_transposition_cipher.sv
